// ===== rtl/slt_pkg.sv =====
// package for the server liveness table
// holds codes, entry layout and the wrap-aware time helpers
// no dependencies
package slt_pkg;

	localparam int unsigned SltDepthDefault = 32;
	localparam logic [31:0] TimeWindow = 32'd86400000;

	localparam logic [15:0] PingIntervalReset = 16'd3000;
	localparam logic [2:0]  PingRetryReset    = 3'd5;
	localparam logic [26:0] KeepaliveReset    = 27'(65 * 60 * 1000);

	typedef enum logic [1:0] {
		FN_REGISTER = 2'd0,
		FN_PONG     = 2'd1,
		FN_TICK     = 2'd2,
		FN_LIST     = 2'd3
	} func_t;

	typedef enum logic [3:0] {
		EV_ADDED      = 4'd0,
		EV_REFRESHED  = 4'd1,
		EV_FULL       = 4'd2,
		EV_CONFIRMED  = 4'd3,
		EV_PONG_NOTED = 4'd4,
		EV_PONG_UNK   = 4'd5,
		EV_SEND_PING  = 4'd6,
		EV_PING_FAIL  = 4'd7,
		EV_KEEP_DROP  = 4'd8,
		EV_TICK_IDLE  = 4'd9,
		EV_LIST_ENTRY = 4'd10,
		EV_LIST_EMPTY = 4'd11
	} event_t;

	typedef enum logic [1:0] {
		REG_PING_INTERVAL = 2'd0,
		REG_PING_RETRY    = 2'd1,
		REG_KEEPALIVE     = 2'd2
	} reg_idx_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic [31:0] host;
		logic [15:0] port;
		logic [31:0] ping;
		logic [31:0] pong;
		logic [2:0]  cnt;
	} entry_t;

	localparam int unsigned EntryW = $bits(entry_t);

	function automatic logic t_greater(input logic [31:0] a, input logic [31:0] b);
		logic [31:0] d;
		d = b - a;
		return d >= TimeWindow;
	endfunction

	function automatic logic [31:0] t_diff(input logic [31:0] a, input logic [31:0] b);
		logic [31:0] d;
		d = a - b;
		return (d >= TimeWindow) ? (b - a) : d;
	endfunction

endpackage

// ===== rtl/slt_ram.sv =====
// generic single write port, single read port ram with registered read
// no dependencies
module slt_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/server_liveness_table.sv =====
// server liveness table: ordered table of game servers with ping bookkeeping
// depends on slt_pkg and slt_ram
//
// usage: a command is taken when start is high and busy is low, with func,
// src_host, src_port and now_ms. each result shows for one cycle with valid
// high; last marks the final result of the command. the receiver cannot stall.
// register and pong scan the table until the first match; tick and list walk
// every entry. one entry is read per cycle from a single ram with registered
// read, results following as they are found. a tick compacts the table as it
// goes, writing kept entries back below the read pointer. reset empties the
// table and loads the register defaults; the ram itself needs no clearing.
// configuration is on an apb-style port at byte addresses 0, 4 and 8; the user
// must write it only while the block is idle, which the block itself does not
// enforce.
module server_liveness_table
	import slt_pkg::*;
#(
	parameter int unsigned TABLE_DEPTH = SltDepthDefault
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  func,
	input  logic [31:0] src_host,
	input  logic [15:0] src_port,
	input  logic [31:0] now_ms,
	output logic        valid,
	output logic [3:0]  event_res,
	output logic [31:0] entry_host,
	output logic [15:0] entry_port,
	output logic        list_changed,
	output logic        last,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int unsigned AW = $clog2(TABLE_DEPTH);
	localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
	localparam logic [CW-1:0] DepthC = CW'(TABLE_DEPTH);

	// configuration
	logic [15:0] ping_interval_q;
	logic [2:0]  ping_retry_q;
	logic [26:0] keepalive_q;
	logic        cfg_wr;
	reg_idx_t    cfg_idx;

	assign pready  = 1'b1;
	assign cfg_wr  = psel & penable & pwrite;
	assign cfg_idx = reg_idx_t'(paddr[3:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ping_interval_q <= PingIntervalReset;
			ping_retry_q    <= PingRetryReset;
			keepalive_q     <= KeepaliveReset;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				REG_PING_INTERVAL: ping_interval_q <= pwdata[15:0];
				REG_PING_RETRY:    ping_retry_q    <= pwdata[2:0];
				REG_KEEPALIVE:     keepalive_q     <= pwdata[26:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (cfg_idx)
			REG_PING_INTERVAL: prdata = {16'd0, ping_interval_q};
			REG_PING_RETRY:    prdata = {29'd0, ping_retry_q};
			REG_KEEPALIVE:     prdata = {5'd0, keepalive_q};
			default:           prdata = 32'd0;
		endcase
	end

	// control and command registers
	state_t      state_q, state_d;
	func_t       func_q;
	logic [31:0] host_q, now_q;
	logic [15:0] port_q;
	logic [CW-1:0] rd_q, rd_d, wr_q, wr_d, cnt_q, cnt_d;
	logic        v_s1, v_d;
	logic [AW-1:0] idx_s1;
	logic        full_q, full_d, hit_q, hit_d;
	logic        pend_v_q, pend_v_d;
	event_t      pend_ev_q, pend_ev_d;
	logic [31:0] pend_host_q, pend_host_d;
	logic [15:0] pend_port_q, pend_port_d;
	logic        pend_chg_q, pend_chg_d;
	logic        out_v_q, out_v_d, out_last_q, out_last_d, out_chg_q, out_chg_d;
	event_t      out_ev_q, out_ev_d;
	logic [31:0] out_host_q, out_host_d;
	logic [15:0] out_port_q, out_port_d;

	// ram
	logic          we, re;
	logic [AW-1:0] waddr;
	entry_t        wdata, ent;
	logic [EntryW-1:0] rdata;

	slt_ram #(.WIDTH(EntryW), .DEPTH(TABLE_DEPTH)) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (re),
		.raddr (rd_q[AW-1:0]),
		.rdata (rdata)
	);

	assign ent = entry_t'(rdata);

	logic        accept;
	logic [31:0] stamp;
	logic        answered, due, conf, stop;
	logic        gen;
	event_t      gen_ev;
	logic [31:0] gen_host;
	logic [15:0] gen_port;
	logic        gen_chg;

	assign accept = start & ~busy;
	assign busy   = (state_q != ST_IDLE);
	assign stamp  = (now_q == 32'd0) ? 32'd1 : now_q;

	assign answered = (ent.ping != 32'd0) && (ent.pong != 32'd0) && !t_greater(ent.ping, ent.pong);
	assign due      = (ent.ping == 32'd0) || (t_diff(now_q, ent.ping) > {16'd0, ping_interval_q});
	assign conf     = (ent.ping != 32'd0) && ((ent.pong == 32'd0) || t_greater(ent.ping, ent.pong));

	always_comb begin
		state_d     = state_q;
		rd_d        = rd_q;
		wr_d        = wr_q;
		cnt_d       = cnt_q;
		v_d         = 1'b0;
		full_d      = full_q;
		hit_d       = hit_q;
		pend_v_d    = pend_v_q;
		pend_ev_d   = pend_ev_q;
		pend_host_d = pend_host_q;
		pend_port_d = pend_port_q;
		pend_chg_d  = pend_chg_q;
		out_v_d     = 1'b0;
		out_last_d  = 1'b0;
		out_ev_d    = pend_ev_q;
		out_host_d  = pend_host_q;
		out_port_d  = pend_port_q;
		out_chg_d   = pend_chg_q;
		we          = 1'b0;
		waddr       = idx_s1;
		wdata       = ent;
		re          = 1'b0;
		stop        = 1'b0;
		gen         = 1'b0;
		gen_ev      = EV_LIST_ENTRY;
		gen_host    = ent.host;
		gen_port    = ent.port;
		gen_chg     = 1'b0;

		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					rd_d     = '0;
					wr_d     = '0;
					hit_d    = 1'b0;
					pend_v_d = 1'b0;
					full_d   = (func_t'(func) == FN_REGISTER) && (cnt_q >= DepthC);
					state_d  = full_d ? ST_FINISH : ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (v_s1) begin
					unique case (func_q)
						FN_REGISTER: begin
							if (ent.host == host_q && ent.port == port_q) begin
								stop       = 1'b1;
								hit_d      = 1'b1;
								we         = 1'b1;
								wdata.ping = 32'd0;
								wdata.cnt  = 3'd0;
								gen        = 1'b1;
								gen_ev     = EV_REFRESHED;
							end
						end
						FN_PONG: begin
							if (ent.host == host_q && (ent.port + 16'd1) == port_q) begin
								stop       = 1'b1;
								hit_d      = 1'b1;
								we         = 1'b1;
								wdata.pong = stamp;
								gen        = 1'b1;
								gen_ev     = conf ? EV_CONFIRMED : EV_PONG_NOTED;
								gen_chg    = (ent.pong == 32'd0);
							end
						end
						FN_TICK: begin
							waddr = wr_q[AW-1:0];
							if (answered) begin
								if (t_diff(now_q, ent.pong) > {5'd0, keepalive_q}) begin
									gen     = 1'b1;
									gen_ev  = EV_KEEP_DROP;
									gen_chg = 1'b1;
								end else begin
									we   = 1'b1;
									wr_d = wr_q + 1'b1;
								end
							end else if (due) begin
								if (ent.cnt >= ping_retry_q) begin
									gen     = 1'b1;
									gen_ev  = EV_PING_FAIL;
									gen_chg = (ent.pong != 32'd0);
								end else begin
									we         = 1'b1;
									wr_d       = wr_q + 1'b1;
									wdata.cnt  = ent.cnt + 3'd1;
									wdata.ping = stamp;
									gen        = 1'b1;
									gen_ev     = EV_SEND_PING;
								end
							end else begin
								we   = 1'b1;
								wr_d = wr_q + 1'b1;
							end
						end
						FN_LIST: begin
							if (ent.pong != 32'd0) begin
								gen    = 1'b1;
								gen_ev = EV_LIST_ENTRY;
							end
						end
						default: ;
					endcase
				end
				if (gen) begin
					out_v_d     = pend_v_q;
					pend_v_d    = 1'b1;
					pend_ev_d   = gen_ev;
					pend_host_d = gen_host;
					pend_port_d = gen_port;
					pend_chg_d  = gen_chg;
				end
				if (!stop && rd_q < cnt_q) begin
					re   = 1'b1;
					v_d  = 1'b1;
					rd_d = rd_q + 1'b1;
				end
				if (stop || rd_q >= cnt_q) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				out_v_d    = 1'b1;
				out_last_d = 1'b1;
				state_d    = ST_IDLE;
				if (!pend_v_q) begin
					out_chg_d  = 1'b0;
					out_host_d = host_q;
					out_port_d = port_q;
					unique case (func_q)
						FN_REGISTER: out_ev_d = full_q ? EV_FULL : EV_ADDED;
						FN_PONG:     out_ev_d = EV_PONG_UNK;
						FN_TICK: begin
							out_ev_d   = EV_TICK_IDLE;
							out_host_d = 32'd0;
							out_port_d = 16'd0;
						end
						FN_LIST: begin
							out_ev_d   = EV_LIST_EMPTY;
							out_host_d = 32'd0;
							out_port_d = 16'd0;
						end
						default: ;
					endcase
				end
				if (func_q == FN_TICK) begin
					cnt_d = wr_q;
				end
				if (func_q == FN_REGISTER && !full_q && !hit_q) begin
					we         = 1'b1;
					waddr      = cnt_q[AW-1:0];
					wdata.host = host_q;
					wdata.port = port_q;
					wdata.ping = 32'd0;
					wdata.pong = 32'd0;
					wdata.cnt  = 3'd0;
					cnt_d      = cnt_q + 1'b1;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			cnt_q      <= '0;
			rd_q       <= '0;
			wr_q       <= '0;
			v_s1       <= 1'b0;
			full_q     <= 1'b0;
			hit_q      <= 1'b0;
			pend_v_q   <= 1'b0;
			out_v_q    <= 1'b0;
			out_last_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			cnt_q      <= cnt_d;
			rd_q       <= rd_d;
			wr_q       <= wr_d;
			v_s1       <= v_d;
			full_q     <= full_d;
			hit_q      <= hit_d;
			pend_v_q   <= pend_v_d;
			out_v_q    <= out_v_d;
			out_last_q <= out_last_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			func_q <= func_t'(func);
			host_q <= src_host;
			port_q <= src_port;
			now_q  <= now_ms;
		end
		idx_s1      <= rd_q[AW-1:0];
		pend_ev_q   <= pend_ev_d;
		pend_host_q <= pend_host_d;
		pend_port_q <= pend_port_d;
		pend_chg_q  <= pend_chg_d;
		out_ev_q    <= out_ev_d;
		out_host_q  <= out_host_d;
		out_port_q  <= out_port_d;
		out_chg_q   <= out_chg_d;
	end

	assign valid        = out_v_q;
	assign last         = out_last_q;
	assign event_res    = out_ev_q;
	assign entry_host   = out_host_q;
	assign entry_port   = out_port_q;
	assign list_changed = out_chg_q;

endmodule

// ===== rtl/slt_checker.sv =====
// port-level checks for the server liveness table
// depends on slt_pkg; bound to server_liveness_table
module slt_props
	import slt_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic       valid,
	input logic       last,
	input logic [3:0] event_res
);

	// an accepted transaction keeps the block busy
	a_busy_after_start: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("busy not raised");

	// the final result is never followed directly by another
	a_gap_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		valid && last |=> !valid) else $error("result straight after last");

	// more results pending means the block is still working
	a_busy_mid: assert property (@(posedge clk) disable iff (!arst_n)
		valid && !last |-> busy) else $error("idle with results pending");

	a_event_code: assert property (@(posedge clk) disable iff (!arst_n)
		valid |-> event_res <= EV_LIST_EMPTY) else $error("bad event code");

endmodule

bind server_liveness_table slt_props u_slt_props (
	.clk       (clk),
	.arst_n    (arst_n),
	.start     (start),
	.busy      (busy),
	.valid     (valid),
	.last      (last),
	.event_res (event_res)
);
